@@ rtl/core/ptrp_pkg.sv @@
`timescale 1ns / 1ps

package ptrp_pkg;

    localparam int unsigned MAX_RECORD_LEN = 160;

    localparam int unsigned CNT_W = 8;
    localparam int unsigned ACC_W = 64;
    localparam int unsigned VER_W = 63;
    localparam int unsigned QUOTA_W = 33;

    localparam logic [CNT_W-1:0] RECORD_LIMIT = CNT_W'(MAX_RECORD_LEN);

    // Line indexes of the record.
    localparam logic [1:0] LINE_VERSION = 2'd0;
    localparam logic [1:0] LINE_ENABLED = 2'd1;
    localparam logic [1:0] LINE_QUOTA   = 2'd2;

    // Keys, first character in the top byte.
    localparam logic [63:0] KEY_VERSION = "version=";
    localparam logic [63:0] KEY_ENABLED = "enabled=";
    localparam logic [63:0] KEY_QUOTA   = {"quota=", 16'h0000};

    localparam logic [3:0] KEY_LEN_VERSION = 4'd8;
    localparam logic [3:0] KEY_LEN_ENABLED = 4'd8;
    localparam logic [3:0] KEY_LEN_QUOTA   = 4'd6;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic [ACC_W-1:0] QUOTA_MIN = 64'h0000_0000_0400_0000;
    localparam logic [ACC_W-1:0] QUOTA_MAX = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic [CNT_W-1:0]   byte_count;
        logic [1:0]         line_index;
        logic [3:0]         key_position;
        logic               in_digits;
        logic               digit_seen;
        logic [ACC_W-1:0]   accumulator;
        logic               overflowed;
        logic               failed;
        logic               lines_done;
        logic [VER_W-1:0]   version_hold;
        logic               enabled_hold;
        logic [QUOTA_W-1:0] quota_hold;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '0;

    function automatic logic [7:0] key_char(input logic [1:0] line, input logic [2:0] pos);
        logic [63:0] key;
        key = '0;
        case (line)
            LINE_VERSION: key = KEY_VERSION;
            LINE_ENABLED: key = KEY_ENABLED;
            LINE_QUOTA:   key = KEY_QUOTA;
            default:      key = '0;
        endcase
        return key[63 - 8 * int'(pos) -: 8];
    endfunction

    function automatic logic [3:0] key_len(input logic [1:0] line);
        logic [3:0] len;
        len = '0;
        case (line)
            LINE_VERSION: len = KEY_LEN_VERSION;
            LINE_ENABLED: len = KEY_LEN_ENABLED;
            LINE_QUOTA:   len = KEY_LEN_QUOTA;
            default:      len = '0;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/core/ptrp_if.sv @@
`timescale 1ns / 1ps

interface ptrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ptrp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [62:0] version;
    logic        enabled;
    logic [32:0] quota_bytes;

    modport source (output valid, output valid_res, output version, output enabled,
                    output quota_bytes, input ready);
    modport sink   (input valid, input valid_res, input version, input enabled,
                    input quota_bytes, output ready);
endinterface

@@ rtl/core/ptrp_step.sv @@
`timescale 1ns / 1ps

module ptrp_step (
    input  ptrp_pkg::t_parse_state i_cur,
    input  logic [7:0]             i_text_byte,
    output ptrp_pkg::t_parse_state o_nxt
);
    import ptrp_pkg::*;

    logic [3:0]       len;
    logic [7:0]       exp_char;
    logic [3:0]       digit;
    logic [67:0]      acc_x10;
    logic             is_digit;
    logic [ACC_W-1:0] acc;

    assign acc      = i_cur.accumulator;
    assign len      = key_len(i_cur.line_index);
    assign exp_char = key_char(i_cur.line_index, i_cur.key_position[2:0]);
    assign is_digit = (i_text_byte >= CHAR_ZERO) && (i_text_byte <= CHAR_NINE);
    assign digit    = 4'(i_text_byte - CHAR_ZERO);
    // acc * 10 + digit in one wide add; anything above bit 63 is overflow.
    assign acc_x10  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 68'(digit);

    always_comb begin
        o_nxt = i_cur;
        if (i_cur.byte_count >= RECORD_LIMIT) begin
            o_nxt.failed = 1'b1;
        end else begin
            o_nxt.byte_count = i_cur.byte_count + 1'b1;
        end

        if (o_nxt.failed) begin
            // Error is sticky; the rest of the record is consumed.
        end else if (i_cur.lines_done) begin
            o_nxt.failed = 1'b1;
        end else if (!i_cur.in_digits) begin
            if (i_cur.line_index > LINE_QUOTA || i_cur.key_position >= len ||
                i_text_byte != exp_char) begin
                o_nxt.failed = 1'b1;
            end else begin
                o_nxt.key_position = i_cur.key_position + 1'b1;
                if (i_cur.key_position + 1'b1 == len) begin
                    o_nxt.in_digits = 1'b1;
                end
            end
        end else if (i_text_byte == CHAR_NEWLINE) begin
            if (!i_cur.digit_seen || i_cur.overflowed) begin
                o_nxt.failed = 1'b1;
            end else begin
                case (i_cur.line_index)
                    LINE_VERSION: begin
                        if (acc[ACC_W-1]) o_nxt.failed = 1'b1;
                        o_nxt.version_hold = acc[VER_W-1:0];
                    end
                    LINE_ENABLED: begin
                        if (acc[ACC_W-1:1] != '0) o_nxt.failed = 1'b1;
                        o_nxt.enabled_hold = (acc == ACC_W'(1));
                        if (acc == ACC_W'(1) && i_cur.version_hold == '0) begin
                            o_nxt.failed = 1'b1;
                        end
                    end
                    default: begin
                        if (acc < QUOTA_MIN || acc > QUOTA_MAX) o_nxt.failed = 1'b1;
                        o_nxt.quota_hold = acc[QUOTA_W-1:0];
                    end
                endcase
            end
            o_nxt.in_digits    = 1'b0;
            o_nxt.digit_seen   = 1'b0;
            o_nxt.accumulator  = '0;
            o_nxt.overflowed   = 1'b0;
            o_nxt.key_position = '0;
            if (i_cur.line_index >= LINE_QUOTA) begin
                o_nxt.lines_done = 1'b1;
                o_nxt.line_index = LINE_VERSION;
            end else begin
                o_nxt.line_index = i_cur.line_index + 1'b1;
            end
        end else if (is_digit) begin
            o_nxt.digit_seen = 1'b1;
            if (i_cur.overflowed || acc_x10[67:64] != '0) begin
                o_nxt.overflowed = 1'b1;
            end else begin
                o_nxt.accumulator = acc_x10[ACC_W-1:0];
            end
        end else begin
            o_nxt.failed = 1'b1;
        end
    end

endmodule

@@ rtl/core/policy_text_record_parser_unit.sv @@
`timescale 1ns / 1ps

// Policy record parser. Takes one text byte per cycle, back to back, and
// checks the three-line "version=", "enabled=", "quota=" record as it
// streams by; the scan state registers update on every accepted byte. The
// result item appears in the output register on the cycle after the byte
// flagged final is accepted, with the value fields forced to zero when the
// record fails any check, and the scan state returns to its start for the
// next record at that same edge. The input is ready whenever the output
// register is empty or is being emptied in that cycle; a result that waits
// untaken holds off further bytes.
module policy_text_record_parser_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    ptrp_in_if.sink   i_in,
    ptrp_out_if.source o_res
);
    import ptrp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state step_nxt;

    logic               r_out_valid;
    logic               r_valid_res;
    logic [VER_W-1:0]   r_version;
    logic               r_enabled;
    logic [QUOTA_W-1:0] r_quota;

    logic accept;
    logic record_ok;

    ptrp_step u_step (
        .i_cur       (r_state),
        .i_text_byte (i_in.text_byte),
        .o_nxt       (step_nxt)
    );

    assign i_in.ready = !r_out_valid || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign record_ok  = !step_nxt.failed && step_nxt.lines_done;

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = i_in.final_byte ? PARSE_RESET : step_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_in.final_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.final_byte) begin
            r_valid_res <= record_ok;
            r_version   <= record_ok ? step_nxt.version_hold : '0;
            r_enabled   <= record_ok && step_nxt.enabled_hold;
            r_quota     <= record_ok ? step_nxt.quota_hold : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.valid_res   = r_valid_res;
    assign o_res.version     = r_version;
    assign o_res.enabled     = r_enabled;
    assign o_res.quota_bytes = r_quota;

endmodule

@@ rtl/core/ptrp_checker.sv @@
`timescale 1ns / 1ps

module ptrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_final,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_valid_res,
    input logic [62:0] i_version,
    input logic        i_enabled,
    input logic [32:0] i_quota
);

    // A result only appears after a final byte was taken.
    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_final))
        else $error("result appeared without a final byte");

    // Rejected records carry all-zero values.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_valid_res) |->
            (i_version == '0 && !i_enabled && i_quota == '0))
        else $error("invalid result with nonzero values");

    // Accepted records satisfy the range rules.
    a_valid_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_valid_res) |->
            ((!i_enabled || i_version != '0) &&
             i_quota >= 33'h0_0400_0000 && i_quota <= 33'h1_0000_0000))
        else $error("valid result out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_valid_res) && $stable(i_version) &&
             $stable(i_enabled) && $stable(i_quota)))
        else $error("stalled result changed");

endmodule

bind policy_text_record_parser_unit ptrp_checker u_ptrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_final  (i_in.final_byte),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_valid_res (o_res.valid_res),
    .i_version   (o_res.version),
    .i_enabled   (o_res.enabled),
    .i_quota     (o_res.quota_bytes)
);

@@ test/tb_policy_text_record_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_policy_text_record_parser_unit;
    import ptrp_pkg::*;

    localparam int RANDOM_BYTES     = 250;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 16;

    typedef struct packed {
        logic               valid_res;
        logic [VER_W-1:0]   version;
        logic               enabled;
        logic [QUOTA_W-1:0] quota_bytes;
    } t_record_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptrp_in_if  byte_ch ();
    ptrp_out_if result_ch ();

    policy_text_record_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_res   (result_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_record_verdict verdict_q[$];
    logic [7:0]      record_bytes[$];
    string           field_keys[3] = '{"version=", "enabled=", "quota="};

    int error_count  = 0;
    int bytes_fed    = 0;
    int quiet_cycles = 0;
    bit feed_gaps_on  = 1'b1;
    bit drain_gaps_on = 1'b1;
    bit hold_results  = 1'b0;

    // Scan state of the record that is currently streaming in.
    logic [7:0]         rec_count;
    logic [1:0]         rec_line;
    logic [3:0]         rec_key_pos;
    logic               rec_in_digits;
    logic               rec_digit_seen;
    logic [ACC_W-1:0]   rec_acc;
    logic               rec_overflow;
    logic               rec_failed;
    logic               rec_lines_done;
    logic [ACC_W-1:0]   rec_version;
    logic               rec_enabled;
    logic [QUOTA_W-1:0] rec_quota;

    function automatic void clear_record_state();
        rec_count      = '0;
        rec_line       = LINE_VERSION;
        rec_key_pos    = '0;
        rec_in_digits  = 1'b0;
        rec_digit_seen = 1'b0;
        rec_acc        = '0;
        rec_overflow   = 1'b0;
        rec_failed     = 1'b0;
        rec_lines_done = 1'b0;
        rec_version    = '0;
        rec_enabled    = 1'b0;
        rec_quota      = '0;
    endfunction

    function automatic void close_value_line();
        if (!rec_digit_seen || rec_overflow) begin
            rec_failed = 1'b1;
        end else if (rec_line == LINE_VERSION) begin
            if (rec_acc[ACC_W-1]) begin
                rec_failed = 1'b1;
            end
            rec_version = rec_acc;
        end else if (rec_line == LINE_ENABLED) begin
            if (rec_acc > 1) begin
                rec_failed = 1'b1;
            end
            rec_enabled = (rec_acc == 1);
            if (rec_enabled && rec_version == 0) begin
                rec_failed = 1'b1;
            end
        end else begin
            if (rec_acc < QUOTA_MIN || rec_acc > QUOTA_MAX) begin
                rec_failed = 1'b1;
            end
            rec_quota = rec_acc[QUOTA_W-1:0];
        end
        rec_in_digits  = 1'b0;
        rec_digit_seen = 1'b0;
        rec_acc        = '0;
        rec_overflow   = 1'b0;
        rec_key_pos    = '0;
        if (rec_line >= LINE_QUOTA) begin
            rec_lines_done = 1'b1;
            rec_line       = LINE_VERSION;
        end else begin
            rec_line = rec_line + 2'd1;
        end
    endfunction

    // Advances the scan by one accepted byte and queues the verdict on the final one.
    function automatic void predict_byte(input logic [7:0] value, input logic last);
        logic [67:0]     wide;
        logic            ok;
        t_record_verdict verdict;
        if (rec_count >= MAX_RECORD_LEN) begin
            rec_failed = 1'b1;
        end else begin
            rec_count = rec_count + 8'd1;
        end
        if (!rec_failed) begin
            if (rec_lines_done) begin
                rec_failed = 1'b1;
            end else if (!rec_in_digits) begin
                if (rec_line > LINE_QUOTA || rec_key_pos >= field_keys[rec_line].len() ||
                    value != field_keys[rec_line][rec_key_pos]) begin
                    rec_failed = 1'b1;
                end else begin
                    rec_key_pos = rec_key_pos + 4'd1;
                    if (rec_key_pos == field_keys[rec_line].len()) begin
                        rec_in_digits = 1'b1;
                    end
                end
            end else if (value == CHAR_NEWLINE) begin
                close_value_line();
            end else if (value >= CHAR_ZERO && value <= CHAR_NINE) begin
                rec_digit_seen = 1'b1;
                wide = 68'(rec_acc) * 68'd10 + 68'(value - CHAR_ZERO);
                if (rec_overflow || wide[67:64] != 4'd0) begin
                    rec_overflow = 1'b1;
                end else begin
                    rec_acc = wide[63:0];
                end
            end else begin
                rec_failed = 1'b1;
            end
        end
        if (last) begin
            ok = !rec_failed && rec_lines_done;
            verdict.valid_res   = ok;
            verdict.version     = ok ? rec_version[VER_W-1:0] : '0;
            verdict.enabled     = ok && rec_enabled;
            verdict.quota_bytes = ok ? rec_quota : '0;
            verdict_q.push_back(verdict);
            clear_record_state();
        end
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = feed_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.text_byte  <= value;
        byte_ch.final_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        predict_byte(value, last);
        bytes_fed++;
    endtask

    task automatic send_record();
        for (int i = 0; i < record_bytes.size(); i++) begin
            send_byte(record_bytes[i], i == record_bytes.size() - 1);
        end
        record_bytes.delete();
    endtask

    task automatic wait_for_verdicts();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            record_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void add_record(input string ver, input string en, input string quota);
        add_text({"version=", ver, "\n", "enabled=", en, "\n", "quota=", quota, "\n"});
    endfunction

    function automatic string zero_run(input int count);
        string s;
        s = "";
        repeat (count) s = {s, "0"};
        return s;
    endfunction

    function automatic string pick_version();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0: return "0";
            1: return $sformatf("%0d", $urandom_range(1, 9));
            5: return "9223372036854775807";
            6: return "9223372036854775808";
            7: return "18446744073709551615";
            8: return "18446744073709551616";
            9: return {zero_run($urandom_range(1, 5)), $sformatf("%0d", $urandom_range(0, 999))};
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic string pick_enabled();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return "0";
            8: return {"0", $sformatf("%0d", $urandom_range(0, 9))};
            9: return $sformatf("%0d", $urandom_range(2, 99));
            default: return "1";
        endcase
    endfunction

    function automatic string pick_quota();
        logic [63:0] q;
        case ($urandom_range(0, 9))
            6: q = QUOTA_MIN - 64'($urandom_range(0, 1));
            7: q = QUOTA_MAX + 64'($urandom_range(0, 1));
            8: q = {$urandom, $urandom} >> $urandom_range(0, 63);
            9: q = 64'($urandom_range(0, 99999));
            default: q = QUOTA_MIN + ({$urandom, $urandom} % (QUOTA_MAX - QUOTA_MIN + 64'd1));
        endcase
        return $sformatf("%0d", q);
    endfunction

    // Changes a well-formed record in one of several ways that can break it; it never becomes empty.
    function automatic void corrupt_record();
        int pos;
        pos = $urandom_range(0, record_bytes.size() - 1);
        case ($urandom_range(0, 5))
            0: record_bytes[pos] = 8'($urandom_range(0, 255));
            1: begin
                while (record_bytes.size() > pos + 1) void'(record_bytes.pop_back());
            end
            2: repeat ($urandom_range(1, 4)) record_bytes.push_back(8'($urandom_range(0, 255)));
            3: begin
                if (record_bytes.size() > 1) begin
                    record_bytes.delete(pos);
                end
            end
            4: record_bytes.insert(pos, 8'($urandom_range(0, 255)));
            default: begin
                record_bytes.delete();
                repeat ($urandom_range(1, 40)) record_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    task automatic test_value_limits();
        string limits[$][3];
        limits = '{
            '{"1", "1", "67108864"},
            '{"0", "0", "4294967296"},
            '{"9223372036854775807", "1", "67108864"},
            '{"9223372036854775808", "0", "67108864"},
            '{"18446744073709551615", "0", "100000000"},
            '{"18446744073709551616", "0", "100000000"},
            '{"0", "1", "67108864"},
            '{"5", "2", "67108864"},
            '{"5", "0", "67108863"},
            '{"5", "0", "4294967297"},
            '{"5", "0", "99999999999999999999999"}
        };
        foreach (limits[i]) begin
            add_record(limits[i][0], limits[i][1], limits[i][2]);
            send_record();
        end
        add_record({zero_run(30), "7"}, "01", "067108864");
        send_record();
        wait_for_verdicts();
    endtask

    task automatic test_malformed_text();
        add_record("", "1", "67108864");
        send_record();
        add_record("1a", "1", "67108864");
        send_record();
        add_text("versiom=1\nenabled=1\nquota=67108864\n");
        send_record();
        add_text("enabled=1\nversion=1\nquota=67108864\n");
        send_record();
        // A newline that arrives while the key is still being matched.
        add_text("vers\nion=1\nenabled=1\nquota=67108864\n");
        send_record();
        add_record("3", "1", "70000000");
        add_text("\n");
        send_record();
        add_text("version=1\nenabled=1\nquota=67108864");
        send_record();
        add_text("version=12");
        send_record();
        record_bytes.push_back(8'hFF);
        send_record();
        wait_for_verdicts();
    endtask

    task automatic test_record_length();
        // Leading zeros on the quota stretch the record without changing its value.
        add_record("1", "1", {zero_run(124), "67108864"});
        send_record();
        add_record("1", "1", {zero_run(125), "67108864"});
        send_record();
        add_record("1", "1", {zero_run(126), "67108864"});
        send_record();
        add_record("2", "0", "67108864");
        repeat (20) record_bytes.push_back(8'($urandom_range(0, 255)));
        send_record();
        wait_for_verdicts();
    endtask

    task automatic test_output_backpressure();
        hold_results = 1'b1;
        feed_gaps_on = 1'b0;
        repeat (4) begin
            add_record(pick_version(), pick_enabled(), pick_quota());
            send_record();
        end
        feed_gaps_on = 1'b1;
        wait_for_verdicts();
    endtask

    task automatic test_random_records();
        int    target;
        string quota;
        target = bytes_fed + RANDOM_BYTES;
        while (bytes_fed < target) begin
            if ($urandom_range(0, 15) == 0) begin
                feed_gaps_on  = $urandom_range(0, 2) != 0;
                drain_gaps_on = $urandom_range(0, 2) != 0;
            end
            quota = pick_quota();
            if ($urandom_range(0, 15) == 0) begin
                quota = {zero_run($urandom_range(100, 140)), quota};
            end
            add_record(pick_version(), pick_enabled(), quota);
            if ($urandom_range(0, 9) < 3) begin
                corrupt_record();
            end
            send_record();
        end
        feed_gaps_on  = 1'b1;
        drain_gaps_on = 1'b1;
        wait_for_verdicts();
    endtask

    initial begin : result_drain
        int stall;
        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = drain_gaps_on ? $urandom_range(0, 8) : 0;
            if (hold_results) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_record_verdict want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (verdict_q.size() == 0) begin
                $error("result item arrived with no record pending");
                error_count++;
            end else begin
                want = verdict_q.pop_front();
                if (result_ch.valid_res !== want.valid_res) begin
                    $error("valid_res mismatch: expected %0d, got %0d",
                           want.valid_res, result_ch.valid_res);
                    error_count++;
                end
                if (result_ch.version !== want.version) begin
                    $error("version mismatch: expected %0d, got %0d",
                           want.version, result_ch.version);
                    error_count++;
                end
                if (result_ch.enabled !== want.enabled) begin
                    $error("enabled mismatch: expected %0d, got %0d",
                           want.enabled, result_ch.enabled);
                    error_count++;
                end
                if (result_ch.quota_bytes !== want.quota_bytes) begin
                    $error("quota_bytes mismatch: expected %0d, got %0d",
                           want.quota_bytes, result_ch.quota_bytes);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("policy_text_record_parser_unit test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.text_byte  = 8'h00;
        byte_ch.final_byte = 1'b0;
        clear_record_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_value_limits();
        test_malformed_text();
        test_record_length();
        test_output_backpressure();
        test_random_records();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("policy_text_record_parser_unit test passed");
        end else begin
            $display("policy_text_record_parser_unit test failed");
        end
        $finish;
    end

endmodule
